// File: rtl/skr_pkg.sv
// Shared types, constants and helpers for the split key state reconciler.
package skr_pkg;

    localparam int ROWS      = 4;
    localparam int COLS      = 12;
    localparam int MAP_BITS  = 48;
    localparam int MAP_IDX_W = $clog2(MAP_BITS);
    localparam int POS_W     = $clog2(ROWS * COLS + 1);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    // input action codes
    localparam logic [1:0] ACT_KEY     = 2'd0;
    localparam logic [1:0] ACT_BEAT    = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_KEY     = 2'd0;
    localparam logic [1:0] KIND_PRESS   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_ID      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [1:0]          action;
        logic [3:0]          key_row;
        logic [3:0]          key_col;
        logic                key_down;
        logic [7:0]          event_seq;
        logic                retry_flag;
        logic [MAP_BITS-1:0] beat_map;
        logic [31:0]         time_now;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       changed;
        logic [3:0] out_row;
        logic [3:0] out_col;
        logic       out_side;
        logic       last;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_KEY,
        OP_BEAT,
        OP_TIMEOUT
    } op_t;

    // classified command handed from the front to the back
    typedef struct packed {
        op_t                 op;
        logic                key_ok;
        logic [POS_W-1:0]    pos;
        logic                key_down;
        logic [7:0]          event_seq;
        logic                retry_flag;
        logic [MAP_BITS-1:0] beat_map;
        logic [31:0]         time_now;
    } cmd_t;

    function automatic logic [MAP_IDX_W-1:0] map_idx(input logic [POS_W-1:0] p);
        return MAP_IDX_W'(p);
    endfunction

endpackage

// File: rtl/skr_front.sv
// Front end: takes input transactions, bounds-checks keys and builds commands.
module skr_front (
    input  logic             start,
    input  logic             busy,
    input  skr_pkg::in_item_t item,
    output logic             push,
    output skr_pkg::cmd_t    cmd
);
    import skr_pkg::*;

    logic             in_bounds;
    logic [POS_W-1:0] pos;

    assign in_bounds = (int'(item.key_row) < ROWS) && (int'(item.key_col) < COLS);
    // only meaningful when in bounds, where it fits POS_W
    assign pos = POS_W'(int'(item.key_row) * COLS + int'(item.key_col));

    always_comb
    begin
        cmd.key_ok     = in_bounds && (int'(pos) < MAP_BITS);
        cmd.pos        = pos;
        cmd.key_down   = item.key_down;
        cmd.event_seq  = item.event_seq;
        cmd.retry_flag = item.retry_flag;
        cmd.beat_map   = item.beat_map;
        cmd.time_now   = item.time_now;
        cmd.op         = OP_KEY;
        push           = 1'b0;
        case (item.action)
            ACT_KEY:
            begin
                cmd.op = OP_KEY;
                push   = start && !busy;
            end
            ACT_BEAT:
            begin
                cmd.op = OP_BEAT;
                push   = start && !busy;
            end
            ACT_TIMEOUT:
            begin
                cmd.op = OP_TIMEOUT;
                push   = start && !busy;
            end
            default:
            begin
                // unused action: accepted and dropped
                push = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/skr_queue.sv
// Two-entry command queue between front and back.
module skr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  skr_pkg::cmd_t push_cmd,
    input  logic          pop,
    output skr_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);
    import skr_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign empty   = (count_reg == 2'd0);
    assign full    = (count_reg == 2'd2);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: rtl/skr_back.sv
// Back end: key map state, link tracking and the reconcile scan.
module skr_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  skr_pkg::cmd_t                head,
    input  logic                         empty,
    output logic                         pop,
    input  logic                         side_id,
    input  logic [31:0]                  link_timeout,
    output logic                         strobe,
    output skr_pkg::out_item_t           result
);
    import skr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [MAP_BITS-1:0] held_reg, held_next;
    logic [MAP_BITS-1:0] want_reg, want_next;
    logic                seq_known_reg, seq_known_next;
    logic [7:0]          prior_seq_reg, prior_seq_next;
    logic [31:0]         beat_time_reg, beat_time_next;
    logic                link_alive_reg, link_alive_next;
    logic [3:0]          row_reg, row_next;
    logic [3:0]          col_reg, col_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                strobe_reg, strobe_next;
    out_item_t           result_reg, result_next;

    logic [MAP_IDX_W-1:0] key_idx;
    logic [MAP_IDX_W-1:0] scan_idx;
    logic                 dup;
    logic [31:0]          elapsed;
    logic                 expired;
    logic                 scan_end;

    assign pop      = (state_reg == ST_IDLE) && !empty;
    assign key_idx  = map_idx(head.pos);
    assign scan_idx = map_idx(pos_reg);
    assign dup      = seq_known_reg && (head.event_seq == prior_seq_reg) && !head.retry_flag;
    assign elapsed  = head.time_now - beat_time_reg;
    assign expired  = link_alive_reg && (elapsed > link_timeout);
    assign scan_end = (row_reg == 4'(ROWS - 1)) && (col_reg == 4'(COLS - 1));

    always_comb
    begin
        state_next      = state_reg;
        held_next       = held_reg;
        want_next       = want_reg;
        seq_known_next  = seq_known_reg;
        prior_seq_next  = prior_seq_reg;
        beat_time_next  = beat_time_reg;
        link_alive_next = link_alive_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        pos_next        = pos_reg;
        strobe_next     = 1'b0;
        result_next     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                row_next = 4'd0;
                col_next = 4'd0;
                pos_next = '0;
                if (!empty)
                begin
                    case (head.op)
                        OP_KEY:
                        begin
                            strobe_next      = 1'b1;
                            result_next.kind = KIND_KEY;
                            result_next.last = 1'b1;
                            if (head.key_ok && !dup)
                            begin
                                prior_seq_next = head.event_seq;
                                seq_known_next = 1'b1;
                                if (held_reg[key_idx] != head.key_down)
                                begin
                                    held_next[key_idx] = head.key_down;
                                    result_next.changed = 1'b1;
                                end
                            end
                        end
                        OP_BEAT:
                        begin
                            want_next       = head.beat_map;
                            beat_time_next  = head.time_now;
                            link_alive_next = 1'b1;
                            state_next      = ST_SCAN;
                        end
                        OP_TIMEOUT:
                        begin
                            if (expired)
                            begin
                                want_next       = '0;
                                link_alive_next = 1'b0;
                                state_next      = ST_SCAN;
                            end
                            else
                            begin
                                strobe_next      = 1'b1;
                                result_next.kind = KIND_DONE;
                                result_next.last = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // one map position per cycle, row-major
                if ((int'(pos_reg) < MAP_BITS) && (want_reg[scan_idx] != held_reg[scan_idx]))
                begin
                    held_next[scan_idx]  = want_reg[scan_idx];
                    strobe_next          = 1'b1;
                    result_next.kind     = want_reg[scan_idx] ? KIND_PRESS : KIND_RELEASE;
                    result_next.out_row  = row_reg;
                    result_next.out_col  = col_reg;
                    result_next.out_side = side_id;
                end
                pos_next = pos_reg + POS_W'(1);
                if (scan_end)
                    state_next = ST_DONE;
                else if (col_reg == 4'(COLS - 1))
                begin
                    col_next = 4'd0;
                    row_next = row_reg + 4'd1;
                end
                else
                    col_next = col_reg + 4'd1;
            end
            ST_DONE:
            begin
                strobe_next      = 1'b1;
                result_next.kind = KIND_DONE;
                result_next.last = 1'b1;
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            held_reg       <= '0;
            want_reg       <= '0;
            seq_known_reg  <= 1'b0;
            prior_seq_reg  <= 8'd0;
            beat_time_reg  <= 32'd0;
            link_alive_reg <= 1'b0;
            row_reg        <= 4'd0;
            col_reg        <= 4'd0;
            pos_reg        <= '0;
            strobe_reg     <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            held_reg       <= held_next;
            want_reg       <= want_next;
            seq_known_reg  <= seq_known_next;
            prior_seq_reg  <= prior_seq_next;
            beat_time_reg  <= beat_time_next;
            link_alive_reg <= link_alive_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            pos_reg        <= pos_next;
            strobe_reg     <= strobe_next;
            result_reg     <= result_next;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

// File: rtl/split_key_state_reconciler_core.sv
// Top level of the split key state reconciler: config registers, front, queue, back.
//
//  channel  | signals                          | transfer
//  ---------+----------------------------------+-----------------------------------
//  input    | start, busy, item                | start && !busy at clk rise
//  result   | strobe, result                   | strobe high for one cycle, no stall
//  config   | cfg_we, cfg_index, cfg_data      | cfg_we at clk rise, no wait
//
// Key event: the command is queued, then the back end registers its result once idle.
// Heartbeat or expired timeout: a full map scan (one scan cycle per
// map position, set by the single-position compare in the back end), results
// during the scan, done at the end. Unexpired timeout: done straight from idle.
// Two commands queue in front of the back end; busy rises when both are taken.
// Reset clears the map, link state and queue at once; no clearing pass.
module split_key_state_reconciler_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  skr_pkg::in_item_t                  item,
    output logic                               strobe,
    output skr_pkg::out_item_t                 result,
    input  logic                               cfg_we,
    input  logic [skr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [skr_pkg::CFG_W-1:0]          cfg_data
);
    import skr_pkg::*;

    logic        side_id_reg;
    logic [31:0] link_timeout_reg;
    logic        push;
    cmd_t        push_cmd;
    logic        pop;
    cmd_t        head;
    logic        empty;
    logic        full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_id_reg      <= 1'b0;
            link_timeout_reg <= 32'd1000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SIDE_ID:      side_id_reg      <= cfg_data[0];
                REG_LINK_TIMEOUT: link_timeout_reg <= cfg_data[31:0];
                default:          ;
            endcase
        end
    end

    assign busy = full;

    skr_front u_front (
        .start (start),
        .busy  (busy),
        .item  (item),
        .push  (push),
        .cmd   (push_cmd)
    );

    skr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    skr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .side_id      (side_id_reg),
        .link_timeout (link_timeout_reg),
        .strobe       (strobe),
        .result       (result)
    );

endmodule

// File: rtl/skr_check.sv
// Port-level checker for the split key state reconciler, bound to the top level.
module skr_check (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               strobe,
    input skr_pkg::out_item_t                 result
);
    import skr_pkg::*;

    // key results and done markers close a transaction
    a_last_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.kind == KIND_KEY || result.kind == KIND_DONE) |-> result.last)
        else $error("key or done result without last");

    // forced events never close a transaction
    a_forced_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.kind == KIND_PRESS || result.kind == KIND_RELEASE) |-> !result.last)
        else $error("forced event marked last");

    a_changed_key_only: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.changed |-> result.kind == KIND_KEY)
        else $error("changed set outside a key result");

    a_forced_follows: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.kind == KIND_PRESS || result.kind == KIND_RELEASE)
        |=> strobe ? (result.kind != KIND_KEY) : 1'b1)
        else $error("key result in the middle of a scan");

endmodule

bind split_key_state_reconciler_core skr_check u_check (.*);

// File: test/tb_split_key_state_reconciler_core.sv
// Self-checking testbench for split_key_state_reconciler_core with a built-in key map predictor.
module tb_split_key_state_reconciler_core;
    timeunit 1ns;
    timeprecision 1ps;

    import skr_pkg::*;

    localparam logic [1:0] ACT_SPARE = 2'd3;
    // room for the two queued commands, each taking the longest back-end pass, plus margin
    localparam int SETTLE_CYCLES = 2 * (ROWS * COLS + 2) + 10;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    in_item_t             item = '0;
    logic                 strobe;
    out_item_t            result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    split_key_state_reconciler_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .strobe    (strobe),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic                side_cfg = 1'b0;
    logic [31:0]         link_limit = 32'd1000;
    logic [MAP_BITS-1:0] held_keys = '0;
    logic                seq_seen = 1'b0;
    logic [7:0]          prev_seq_id = '0;
    logic [31:0]         beat_stamp = '0;
    logic                link_up = 1'b0;

    in_item_t  cmd_backlog[$];
    out_item_t due_reports[$];

    int queued_count = 0;
    int taken_count = 0;
    int fail_count = 0;
    int checked_count = 0;
    int key_count = 0;
    int change_count = 0;
    int beat_count = 0;
    int check_count = 0;
    int expired_count = 0;
    int forced_count = 0;

    bit quiet = 1'b0;
    int gap_left = 0;
    int calm_left = 0;

    // stimulus generator's own view of time, map and sequence
    logic [31:0]         gen_ms;
    logic [31:0]         gen_beat;
    logic [MAP_BITS-1:0] gen_map;
    logic [7:0]          gen_seq;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("split_key_state_reconciler_core test failed");
        $finish;
    end

    // walk every position in order, forcing held_keys toward target
    function automatic void sweep(input logic [MAP_BITS-1:0] target);
        out_item_t rep;
        int pos;
        for (int r = 0; r < ROWS; r++)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                pos = r * COLS + c;
                if (pos < MAP_BITS && target[pos] != held_keys[pos])
                begin
                    rep = '0;
                    rep.kind = target[pos] ? KIND_PRESS : KIND_RELEASE;
                    rep.out_row = 4'(r);
                    rep.out_col = 4'(c);
                    rep.out_side = side_cfg;
                    held_keys[pos] = target[pos];
                    due_reports.push_back(rep);
                    forced_count++;
                end
            end
        end
    endfunction

    function automatic void reconcile(input in_item_t cmd);
        out_item_t rep;
        int pos;
        logic [31:0] elapsed;
        rep = '0;
        rep.last = 1'b1;
        case (cmd.action)
            ACT_KEY:
            begin
                key_count++;
                pos = int'(cmd.key_row) * COLS + int'(cmd.key_col);
                rep.kind = KIND_KEY;
                if (cmd.key_row < ROWS && cmd.key_col < COLS && pos < MAP_BITS &&
                    !(seq_seen && cmd.event_seq == prev_seq_id && !cmd.retry_flag))
                begin
                    prev_seq_id = cmd.event_seq;
                    seq_seen = 1'b1;
                    if (held_keys[pos] != cmd.key_down)
                    begin
                        held_keys[pos] = cmd.key_down;
                        rep.changed = 1'b1;
                        change_count++;
                    end
                end
                due_reports.push_back(rep);
            end
            ACT_BEAT:
            begin
                beat_count++;
                sweep(cmd.beat_map);
                beat_stamp = cmd.time_now;
                link_up = 1'b1;
                rep.kind = KIND_DONE;
                due_reports.push_back(rep);
            end
            ACT_TIMEOUT:
            begin
                check_count++;
                elapsed = cmd.time_now - beat_stamp;
                if (link_up && elapsed > link_limit)
                begin
                    sweep('0);
                    link_up = 1'b0;
                    expired_count++;
                end
                rep.kind = KIND_DONE;
                due_reports.push_back(rep);
            end
            default:
            begin
            end
        endcase
    endfunction

    // driver: one transaction at a time from the backlog, random idle bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                reconcile(item);
                taken_count++;
                if (!quiet)
                begin
                    if (calm_left > 0)
                        calm_left--;
                    else if ($urandom_range(0, 7) == 0)
                        calm_left = $urandom_range(10, 40);
                    else if ($urandom_range(0, 2) == 0)
                        gap_left = $urandom_range(1, 9);
                end
            end
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (cmd_backlog.size() > 0)
                begin
                    item <= cmd_backlog.pop_front();
                    start <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobe must match the oldest outstanding expectation
    out_item_t want;
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (due_reports.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d changed=%0d row=%0d col=%0d side=%0d last=%0d",
                         $realtime, result.kind, result.changed, result.out_row,
                         result.out_col, result.out_side, result.last);
                fail_count++;
            end
            else
            begin
                want = due_reports.pop_front();
                checked_count++;
                if (result.kind !== want.kind || result.changed !== want.changed ||
                    result.out_row !== want.out_row || result.out_col !== want.out_col ||
                    result.out_side !== want.out_side || result.last !== want.last)
                begin
                    $display("%0t: mismatch expected kind=%0d changed=%0d row=%0d col=%0d side=%0d last=%0d",
                             $realtime, want.kind, want.changed, want.out_row,
                             want.out_col, want.out_side, want.last);
                    $display("%0t:          actual   kind=%0d changed=%0d row=%0d col=%0d side=%0d last=%0d",
                             $realtime, result.kind, result.changed, result.out_row,
                             result.out_col, result.out_side, result.last);
                    fail_count++;
                end
            end
        end
    end

    function automatic in_item_t noise_item();
        in_item_t it;
        it.action = ACT_SPARE;
        it.key_row = 4'($urandom);
        it.key_col = 4'($urandom);
        it.key_down = 1'($urandom);
        it.event_seq = 8'($urandom);
        it.retry_flag = 1'($urandom);
        it.beat_map = {16'($urandom), 32'($urandom)};
        it.time_now = $urandom;
        return it;
    endfunction

    task automatic submit(input in_item_t it);
        cmd_backlog.push_back(it);
        queued_count++;
    endtask

    task automatic key_cmd(input logic [3:0] row, input logic [3:0] col, input logic down,
                           input logic [7:0] seq, input logic retry);
        in_item_t it;
        it = noise_item();
        it.action = ACT_KEY;
        it.key_row = row;
        it.key_col = col;
        it.key_down = down;
        it.event_seq = seq;
        it.retry_flag = retry;
        submit(it);
    endtask

    task automatic beat_cmd(input logic [MAP_BITS-1:0] map, input logic [31:0] now);
        in_item_t it;
        it = noise_item();
        it.action = ACT_BEAT;
        it.beat_map = map;
        it.time_now = now;
        submit(it);
    endtask

    task automatic check_cmd(input logic [31:0] now);
        in_item_t it;
        it = noise_item();
        it.action = ACT_TIMEOUT;
        it.time_now = now;
        submit(it);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SIDE_ID)
            side_cfg = val[0];
        else
            link_limit = val;
    endtask

    task automatic settle();
        while (taken_count != queued_count || due_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // time offset: short, near the timeout edge, anything, or within the timeout
    function automatic logic [31:0] time_step();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 50);
            1: return link_limit + 32'($urandom_range(0, 4)) - 32'd2;
            2: return $urandom;
            default: return (link_limit > 32'd100000) ? $urandom_range(0, 100000)
                                                       : $urandom_range(0, link_limit);
        endcase
    endfunction

    task automatic random_phase(input int count);
        in_item_t it;
        int sel;
        // block is idle here, so the predictor state is the generator's start point
        gen_ms = beat_stamp;
        gen_beat = beat_stamp;
        gen_map = held_keys;
        gen_seq = prev_seq_id;
        for (int i = 0; i < count; i++)
        begin
            it = noise_item();
            sel = $urandom_range(0, 99);
            if (sel < 55)
            begin
                it.action = ACT_KEY;
                if ($urandom_range(0, 9) != 0)
                begin
                    it.key_row = 4'($urandom_range(0, ROWS - 1));
                    it.key_col = 4'($urandom_range(0, COLS - 1));
                end
                case ($urandom_range(0, 5))
                    0: it.event_seq = gen_seq;
                    1: it.event_seq = 8'($urandom);
                    default: it.event_seq = gen_seq + 8'd1;
                endcase
                it.retry_flag = ($urandom_range(0, 3) == 0);
                gen_seq = it.event_seq;
            end
            else if (sel < 75)
            begin
                it.action = ACT_BEAT;
                case ($urandom_range(0, 7))
                    0, 1, 2: it.beat_map = gen_map ^ (48'd1 << $urandom_range(0, MAP_BITS - 1))
                                                   ^ (48'd1 << $urandom_range(0, MAP_BITS - 1));
                    5: it.beat_map = '0;
                    6: it.beat_map = '1;
                    7: it.beat_map = it.beat_map & {16'($urandom), 32'($urandom)};
                    default: ;
                endcase
                it.time_now = gen_ms + (($urandom_range(0, 3) == 0) ? $urandom
                                                                    : $urandom_range(0, 500));
                gen_map = it.beat_map;
                gen_ms = it.time_now;
                gen_beat = it.time_now;
            end
            else if (sel < 95)
            begin
                it.action = ACT_TIMEOUT;
                it.time_now = gen_beat + time_step();
                gen_ms = it.time_now;
            end
            submit(it);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing seen yet, so sequence 0 is fresh; then a repeat and its retry
        key_cmd(4'd0, 4'd0, 1'b1, 8'd0, 1'b0);
        key_cmd(4'd0, 4'd1, 1'b1, 8'd0, 1'b0);
        key_cmd(4'd0, 4'd1, 1'b1, 8'd0, 1'b1);
        // out of bounds must not touch the sequence tracking
        key_cmd(4'd4, 4'd0, 1'b1, 8'd1, 1'b0);
        key_cmd(4'd15, 4'd15, 1'b1, 8'd2, 1'b1);
        key_cmd(4'd0, 4'd12, 1'b1, 8'd3, 1'b0);
        key_cmd(4'd3, 4'd11, 1'b1, 8'd0, 1'b0);
        key_cmd(4'd3, 4'd11, 1'b1, 8'd255, 1'b0);
        key_cmd(4'd3, 4'd11, 1'b1, 8'd254, 1'b0);
        key_cmd(4'd3, 4'd11, 1'b0, 8'd253, 1'b0);
        key_cmd(4'd0, 4'd0, 1'b0, 8'd253, 1'b1);
        check_cmd(32'd5);
        submit(noise_item());
        beat_cmd('1, 32'hFFFF_FFF0);
        // wrapped difference exactly at the timeout, then one past it
        check_cmd(32'hFFFF_FFF0 + 32'd1000);
        check_cmd(32'hFFFF_FFF0 + 32'd1001);
        check_cmd(32'hFFFF_FFF0 + 32'd1002);
        beat_cmd('0, 32'd0);
        beat_cmd({1'b1, 46'd0, 1'b1}, 32'd0);
        key_cmd(4'd3, 4'd11, 1'b0, 8'd7, 1'b0);
        beat_cmd('0, 32'hFFFF_FFFF);
        submit(noise_item());
        check_cmd(32'd0);
        check_cmd(32'hFFFF_FFFF);
        settle();

        set_reg(REG_SIDE_ID, 32'd1);
        set_reg(REG_LINK_TIMEOUT, 32'd0);
        random_phase(115);
        settle();

        set_reg(REG_SIDE_ID, 32'd0);
        set_reg(REG_LINK_TIMEOUT, 32'hFFFF_FFFF);
        random_phase(115);
        settle();

        set_reg(REG_SIDE_ID, 32'd1);
        set_reg(REG_LINK_TIMEOUT, $urandom_range(1, 300));
        random_phase(115);
        settle();

        // closing stretch runs back to back
        quiet = 1'b1;
        set_reg(REG_SIDE_ID, 32'($urandom_range(0, 1)));
        set_reg(REG_LINK_TIMEOUT, 32'd1000);
        random_phase(115);
        settle();

        $display("covered %0d transactions: %0d key events (%0d changed the map), %0d heartbeats,",
                 taken_count, key_count, change_count, beat_count);
        $display("%0d timeout checks (%0d expired); %0d results checked, %0d forced events",
                 check_count, expired_count, checked_count, forced_count);
        if (fail_count == 0)
            $display("split_key_state_reconciler_core test passed");
        else
            $display("split_key_state_reconciler_core test failed");
        $finish;
    end

endmodule

// File: split_key_state_reconciler_core.f
rtl/skr_pkg.sv
rtl/skr_front.sv
rtl/skr_queue.sv
rtl/skr_back.sv
rtl/split_key_state_reconciler_core.sv
rtl/skr_check.sv
test/tb_split_key_state_reconciler_core.sv
